/* design/stam_pkg.sv */
// Shared types and constants for the sparse triplet add/merge block.
// Used by stam_ctrl, stam_dpath and sparse_triplet_add_merge; depends on nothing.
`timescale 1ns / 1ps

package stam_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int INDEX_BITS  = 16;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int POS_W       = 16;
  localparam int VALUE_W     = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Input item modes.
  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_START  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_ENTRY    = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_COLS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_ROWS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUBTRACT = 3'd4;

  typedef struct packed {
    logic [INDEX_BITS-1:0] row;
    logic [INDEX_BITS-1:0] col;
    logic [VALUE_W-1:0]    value;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic begin_merge;
    logic step;
    logic emit_end;
    logic emit_mismatch;
    logic clear;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dim_mismatch;
    logic done;
  } sts_t;

endpackage

/* design/stam_ctrl.sv */
// Controller state machine of the sparse triplet add/merge block.
// Depends on stam_pkg; drives the command struct of stam_dpath.
`timescale 1ns / 1ps

module stam_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [1:0]       mode_i,
  input  stam_pkg::sts_t   sts_i,
  output stam_pkg::cmd_t   cmd_o,
  output logic             busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          priority if (mode_i == stam_pkg::MODE_LOAD_A) begin
            cmd_o.load_a = 1'b1;
          end else if (mode_i == stam_pkg::MODE_LOAD_B) begin
            cmd_o.load_b = 1'b1;
          end else if (mode_i == stam_pkg::MODE_START) begin
            if (sts_i.dim_mismatch) begin
              cmd_o.emit_mismatch = 1'b1;
              cmd_o.clear         = 1'b1;
            end else begin
              cmd_o.begin_merge = 1'b1;
              state_d           = S_READ;
            end
          end else begin
            // The unused mode is taken and dropped.
            state_d = S_IDLE;
          end
        end
      end
      S_READ: begin
        // The store read issued in this cycle lands in the datapath registers.
        if (sts_i.done) begin
          cmd_o.emit_end = 1'b1;
          cmd_o.clear    = 1'b1;
          state_d        = S_IDLE;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.step = 1'b1;
        state_d    = S_READ;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

/* design/stam_dpath.sv */
// Datapath of the sparse triplet add/merge block: entry stores, merge pointers,
// configuration registers, one pending result and the output register. Depends on stam_pkg.
`timescale 1ns / 1ps

module stam_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  stam_pkg::cmd_t                       cmd_i,
  output stam_pkg::sts_t                       sts_o,
  input  logic                                 cfg_we_i,
  input  logic [stam_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [stam_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [stam_pkg::POS_W-1:0]           row_i,
  input  logic [stam_pkg::POS_W-1:0]           col_i,
  input  logic signed [stam_pkg::VALUE_W-1:0]  value_i,
  output logic                                 out_valid_o,
  output logic [stam_pkg::POS_W-1:0]           out_row_o,
  output logic [stam_pkg::POS_W-1:0]           out_col_o,
  output logic signed [stam_pkg::VALUE_W-1:0]  out_value_o,
  output logic [1:0]                           status_o,
  output logic                                 last_o
);

  // Configuration registers.
  logic [stam_pkg::POS_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic                       subtract_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q   <= '0;
      a_cols_q   <= '0;
      b_rows_q   <= '0;
      b_cols_q   <= '0;
      subtract_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        stam_pkg::REG_A_ROWS:   a_rows_q   <= cfg_data_i;
        stam_pkg::REG_A_COLS:   a_cols_q   <= cfg_data_i;
        stam_pkg::REG_B_ROWS:   b_rows_q   <= cfg_data_i;
        stam_pkg::REG_B_COLS:   b_cols_q   <= cfg_data_i;
        stam_pkg::REG_SUBTRACT: subtract_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Fill counts and merge pointers.
  logic [stam_pkg::CNT_W-1:0] a_cnt_q, b_cnt_q, i_q, j_q;
  logic [stam_pkg::CNT_W-1:0] a_cnt_d, b_cnt_d, i_d, j_d;
  logic                       wr_a, wr_b;
  stam_pkg::entry_t           wr_entry;

  assign wr_a = cmd_i.load_a && (a_cnt_q < stam_pkg::CNT_W'(stam_pkg::MAX_ENTRIES));
  assign wr_b = cmd_i.load_b && (b_cnt_q < stam_pkg::CNT_W'(stam_pkg::MAX_ENTRIES));

  assign wr_entry.row   = row_i[stam_pkg::INDEX_BITS-1:0];
  assign wr_entry.col   = col_i[stam_pkg::INDEX_BITS-1:0];
  assign wr_entry.value = value_i;

  // Entry stores with registered reads at the merge pointers.
  stam_pkg::entry_t a_mem [stam_pkg::MAX_ENTRIES];
  stam_pkg::entry_t b_mem [stam_pkg::MAX_ENTRIES];
  stam_pkg::entry_t rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      a_mem[a_cnt_q[stam_pkg::ADDR_W-1:0]] <= wr_entry;
    end
    rd_a_q <= a_mem[i_q[stam_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      b_mem[b_cnt_q[stam_pkg::ADDR_W-1:0]] <= wr_entry;
    end
    rd_b_q <= b_mem[j_q[stam_pkg::ADDR_W-1:0]];
  end

  // Merge compare on the registered store reads.
  logic                       a_ok, b_ok, take_a, take_b, a_before, b_before;
  logic [stam_pkg::VALUE_W-1:0] comb_v, neg_b;
  logic                       cand_valid;
  stam_pkg::entry_t           cand;

  assign a_ok = (i_q < a_cnt_q);
  assign b_ok = (j_q < b_cnt_q);

  assign a_before = (rd_a_q.row < rd_b_q.row) ||
                    ((rd_a_q.row == rd_b_q.row) && (rd_a_q.col < rd_b_q.col));
  assign b_before = (rd_a_q.row > rd_b_q.row) ||
                    ((rd_a_q.row == rd_b_q.row) && (rd_a_q.col > rd_b_q.col));

  assign take_a = !b_ok || (a_ok && a_before);
  assign take_b = !a_ok || (b_ok && b_before);

  assign neg_b  = '0 - rd_b_q.value;
  assign comb_v = subtract_q ? (rd_a_q.value - rd_b_q.value)
                             : (rd_a_q.value + rd_b_q.value);

  always_comb begin
    cand       = rd_a_q;
    cand_valid = 1'b1;
    if (take_a) begin
      cand = rd_a_q;
    end else if (take_b) begin
      cand       = rd_b_q;
      cand.value = subtract_q ? neg_b : rd_b_q.value;
    end else begin
      cand.value = comb_v;
      cand_valid = (comb_v != '0);
    end
  end

  always_comb begin
    a_cnt_d = a_cnt_q;
    b_cnt_d = b_cnt_q;
    i_d     = i_q;
    j_d     = j_q;
    if (wr_a) begin
      a_cnt_d = a_cnt_q + 1'b1;
    end
    if (wr_b) begin
      b_cnt_d = b_cnt_q + 1'b1;
    end
    if (cmd_i.begin_merge) begin
      i_d = '0;
      j_d = '0;
    end
    if (cmd_i.step) begin
      if (!take_b) begin
        i_d = i_q + 1'b1;
      end
      if (!take_a) begin
        j_d = j_q + 1'b1;
      end
    end
    if (cmd_i.clear) begin
      a_cnt_d = '0;
      b_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_cnt_q <= '0;
      b_cnt_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      a_cnt_q <= a_cnt_d;
      b_cnt_q <= b_cnt_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  assign sts_o.done         = !a_ok && !b_ok;
  assign sts_o.dim_mismatch = (a_rows_q != b_rows_q) || (a_cols_q != b_cols_q);

  // One result is held back so that the final one can carry last.
  logic             pend_valid_q, pend_valid_d;
  stam_pkg::entry_t pend_q, pend_d;
  logic             out_valid_q, out_valid_d, last_q, last_d;
  logic [1:0]       status_q, status_d;
  stam_pkg::entry_t out_q, out_d;

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = 1'b0;
    out_d        = pend_q;
    status_d     = stam_pkg::ST_ENTRY;
    last_d       = 1'b0;
    if (cmd_i.begin_merge) begin
      pend_valid_d = 1'b0;
    end
    priority if (cmd_i.emit_mismatch) begin
      out_valid_d = 1'b1;
      out_d       = '0;
      status_d    = stam_pkg::ST_MISMATCH;
      last_d      = 1'b1;
    end else if (cmd_i.emit_end) begin
      out_valid_d  = 1'b1;
      last_d       = 1'b1;
      pend_valid_d = 1'b0;
      if (!pend_valid_q) begin
        out_d    = '0;
        status_d = stam_pkg::ST_EMPTY;
      end
    end else if (cmd_i.step && cand_valid) begin
      out_valid_d  = pend_valid_q;
      pend_valid_d = 1'b1;
      pend_d       = cand;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q   <= pend_d;
    out_q    <= out_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = stam_pkg::POS_W'(out_q.row);
  assign out_col_o   = stam_pkg::POS_W'(out_q.col);
  assign out_value_o = out_q.value;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule

/* design/sparse_triplet_add_merge.sv */
// Top level of the sparse triplet add/merge block.
// Depends on stam_pkg, stam_ctrl and stam_dpath.
`timescale 1ns / 1ps

// Usage:
// An item is taken when start is high and busy is low. Mode load A or load B
// writes one (row, col, value) entry into the matching store and leaves busy
// low, so loads can be given every cycle. A store holds 32 entries; further
// loads are dropped. The unused mode is taken and ignored.
// A start item raises busy and merges both stores in row-major order. Each merge
// step is a registered store read, then a compare and advance, and uses up at
// least one stored entry. A result is held until the next one is found or the
// merge ends, then it is on the result ports for one cycle with out_valid_o
// high; the final one of a start has last_o set. With differing dimensions a
// single mismatch result appears in the cycle after the start transaction.
// Both stores are emptied after every start. Configuration writes through
// cfg_we_i are registered and are to be made while the block is idle; the user
// is bound to this, the block itself does not enforce it. Reset empties the
// stores and zeroes the configuration, counts, pointers and valid flags. The
// receiver cannot stall: every result must be taken in the cycle it is shown.
module sparse_triplet_add_merge (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           mode_i,
  input  logic [stam_pkg::POS_W-1:0]           row_i,
  input  logic [stam_pkg::POS_W-1:0]           col_i,
  input  logic signed [stam_pkg::VALUE_W-1:0]  value_i,
  input  logic                                 cfg_we_i,
  input  logic [stam_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [stam_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                 out_valid_o,
  output logic [stam_pkg::POS_W-1:0]           out_row_o,
  output logic [stam_pkg::POS_W-1:0]           out_col_o,
  output logic signed [stam_pkg::VALUE_W-1:0]  out_value_o,
  output logic [1:0]                           status_o,
  output logic                                 last_o
);

  stam_pkg::cmd_t cmd;
  stam_pkg::sts_t sts;

  stam_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (mode_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  stam_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .out_value_o (out_value_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule
